// ===== rtl/sma_pkg.sv =====
`timescale 1ns / 1ps
// Shared opcodes, status codes, control word types and microcode store of the stack calculator.
package sma_pkg;

  localparam int OPC_W    = 4;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 5;
  localparam int UPC_W    = 5;

  // Instruction opcodes.
  localparam logic [OPC_W-1:0] PSH       = 4'd0;
  localparam logic [OPC_W-1:0] ADD       = 4'd1;
  localparam logic [OPC_W-1:0] MULT      = 4'd2;
  localparam logic [OPC_W-1:0] SUB       = 4'd3;
  localparam logic [OPC_W-1:0] DIV       = 4'd4;
  localparam logic [OPC_W-1:0] CMP       = 4'd5;
  localparam logic [OPC_W-1:0] OP_FINISH = 4'd6;
  localparam logic [OPC_W-1:0] OP_CLEAR  = 4'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNSUPPORTED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;
  localparam logic [STATUS_W-1:0] ST_LEFTOVER    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd6;

  // Microcode addresses.
  localparam logic [UPC_W-1:0] UA_PSH       = 5'd0;
  localparam logic [UPC_W-1:0] UA_PSH_FULL  = 5'd1;
  localparam logic [UPC_W-1:0] UA_FIN       = 5'd2;
  localparam logic [UPC_W-1:0] UA_FIN_ONE   = 5'd3;
  localparam logic [UPC_W-1:0] UA_FIN_EMPTY = 5'd4;
  localparam logic [UPC_W-1:0] UA_FIN_LEFT  = 5'd5;
  localparam logic [UPC_W-1:0] UA_CLR       = 5'd6;
  localparam logic [UPC_W-1:0] UA_BIN       = 5'd7;
  localparam logic [UPC_W-1:0] UA_BIN_OPB   = 5'd8;
  localparam logic [UPC_W-1:0] UA_BIN_KIND  = 5'd9;
  localparam logic [UPC_W-1:0] UA_DIV_CHK   = 5'd10;
  localparam logic [UPC_W-1:0] UA_DIV_WAIT  = 5'd11;
  localparam logic [UPC_W-1:0] UA_PUSH_QUO  = 5'd12;
  localparam logic [UPC_W-1:0] UA_UNS_POP   = 5'd13;
  localparam logic [UPC_W-1:0] UA_UNS_TOP   = 5'd14;
  localparam logic [UPC_W-1:0] UA_DZ_POP    = 5'd15;
  localparam logic [UPC_W-1:0] UA_DZ_TOP    = 5'd16;
  localparam logic [UPC_W-1:0] UA_UFL       = 5'd17;
  localparam logic [UPC_W-1:0] UA_ALU       = 5'd18;
  localparam logic [UPC_W-1:0] UA_PUSH_ALU  = 5'd19;

  // Jump conditions. When the condition holds the word jumps and does nothing else.
  typedef enum logic [3:0] {
    COND_NONE     = 4'd0,
    COND_FULL     = 4'd1,
    COND_UNDER    = 4'd2,
    COND_DZERO    = 4'd3,
    COND_DMULTI   = 4'd4,
    COND_UNSUP    = 4'd5,
    COND_NOT_DIV  = 4'd6,
    COND_DIV_ZERO = 4'd7,
    COND_DIV_BUSY = 4'd8
  } cond_t;

  typedef struct packed {
    cond_t                cond;
    logic [UPC_W-1:0]     target;
    logic                 push_pv;
    logic                 push_res;
    logic                 pop_two;
    logic                 rd_second;
    logic                 rd_below;
    logic                 load_b;
    logic                 load_quo;
    logic                 load_alu;
    logic                 load_top;
    logic                 clear;
    logic                 div_start;
    logic                 emit;
    logic [STATUS_W-1:0]  status;
  } ctrl_t;

  typedef struct packed {
    logic full;
    logic under;
    logic depth_zero;
    logic depth_multi;
    logic unsup;
    logic not_div;
    logic div_zero;
    logic div_busy;
    logic out_busy;
  } flags_t;

  // Entry point of the program for each opcode.
  function automatic logic [UPC_W-1:0] dispatch(input logic [OPC_W-1:0] opcode);
    logic [UPC_W-1:0] addr;
    case (opcode)
      PSH:       addr = UA_PSH;
      OP_FINISH: addr = UA_FIN;
      OP_CLEAR:  addr = UA_CLR;
      default:   addr = UA_BIN;
    endcase
    return addr;
  endfunction

  // Read-only control store. A word that emits also ends the instruction.
  function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
    ctrl_t w;
    w = '0;
    case (addr)
      UA_PSH: begin
        w.cond = COND_FULL;  w.target = UA_PSH_FULL;
        w.push_pv = 1'b1;    w.emit = 1'b1;  w.status = ST_OK;
      end
      UA_PSH_FULL: begin
        w.emit = 1'b1;  w.status = ST_FULL;
      end
      UA_FIN: begin
        w.cond = COND_DZERO;  w.target = UA_FIN_EMPTY;
      end
      UA_FIN_ONE: begin
        w.cond = COND_DMULTI;  w.target = UA_FIN_LEFT;
        w.emit = 1'b1;  w.status = ST_OK;
      end
      UA_FIN_EMPTY: begin
        w.emit = 1'b1;  w.status = ST_EMPTY;
      end
      UA_FIN_LEFT: begin
        w.emit = 1'b1;  w.status = ST_LEFTOVER;
      end
      UA_CLR: begin
        w.clear = 1'b1;  w.emit = 1'b1;  w.status = ST_OK;
      end
      UA_BIN: begin
        w.cond = COND_UNDER;  w.target = UA_UFL;
        w.rd_second = 1'b1;
      end
      UA_BIN_OPB: begin
        w.cond = COND_UNSUP;  w.target = UA_UNS_POP;
        w.load_b = 1'b1;
      end
      UA_BIN_KIND: begin
        w.cond = COND_NOT_DIV;  w.target = UA_ALU;
      end
      UA_DIV_CHK: begin
        w.cond = COND_DIV_ZERO;  w.target = UA_DZ_POP;
        w.div_start = 1'b1;
      end
      UA_DIV_WAIT: begin
        w.cond = COND_DIV_BUSY;  w.target = UA_DIV_WAIT;
        w.load_quo = 1'b1;
      end
      UA_PUSH_QUO: begin
        w.push_res = 1'b1;  w.emit = 1'b1;  w.status = ST_OK;
      end
      UA_UNS_POP: begin
        w.pop_two = 1'b1;  w.rd_below = 1'b1;
      end
      UA_UNS_TOP: begin
        w.load_top = 1'b1;  w.emit = 1'b1;  w.status = ST_UNSUPPORTED;
      end
      UA_DZ_POP: begin
        w.pop_two = 1'b1;  w.rd_below = 1'b1;
      end
      UA_DZ_TOP: begin
        w.load_top = 1'b1;  w.emit = 1'b1;  w.status = ST_DIVZERO;
      end
      UA_UFL: begin
        w.emit = 1'b1;  w.status = ST_UNDERFLOW;
      end
      UA_ALU: begin
        w.load_alu = 1'b1;
      end
      UA_PUSH_ALU: begin
        w.push_res = 1'b1;  w.emit = 1'b1;  w.status = ST_OK;
      end
      default: begin
        w.emit = 1'b1;  w.status = ST_UNSUPPORTED;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/sma_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for instructions in and results out.
interface sma_req_if;
  logic                              valid;
  logic                              ready;
  logic [sma_pkg::OPC_W-1:0]         opcode;
  logic signed [sma_pkg::DATA_W-1:0] push_value;

  modport source (output valid, output opcode, output push_value, input ready);
  modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

interface sma_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [sma_pkg::STATUS_W-1:0]        status;
  logic signed [sma_pkg::DATA_W-1:0]   top_value;
  logic [sma_pkg::COUNT_W-1:0]         stack_count;

  modport source (output valid, output status, output top_value, output stack_count,
                  input ready);
  modport sink   (input valid, input status, input top_value, input stack_count,
                  output ready);
endinterface

// ===== rtl/sma_div.sv =====
`timescale 1ns / 1ps
// Iterative signed divider: one restoring quotient bit per cycle, truncating toward zero.
module sma_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [sma_pkg::DATA_W-1:0]   num,
  input  logic [sma_pkg::DATA_W-1:0]   den,
  output logic                         busy,
  output logic [sma_pkg::DATA_W-1:0]   quo
);
  import sma_pkg::*;

  localparam int W  = DATA_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  qreg;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic          neg;
  logic [W:0]    shifted;
  logic [W:0]    diff;

  always_comb begin
    shifted = {rem, qreg[W-1]};
    diff    = shifted - {1'b0, dvs};
    quo     = neg ? (~qreg + 1'b1) : qreg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Operands are worked on as magnitudes; the sign is put back on the way out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      qreg <= num[W-1] ? (~num + 1'b1) : num;
      dvs  <= den[W-1] ? (~den + 1'b1) : den;
      neg  <= num[W-1] ^ den[W-1];
    end else if (busy) begin
      if (!diff[W]) begin
        rem  <= diff[W-1:0];
        qreg <= {qreg[W-2:0], 1'b1};
      end else begin
        rem  <= shifted[W-1:0];
        qreg <= {qreg[W-2:0], 1'b0};
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

// ===== rtl/sma_seq.sv =====
`timescale 1ns / 1ps
// Microcode sequencer: step counter, control store fetch and conditional jumps.
module sma_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [sma_pkg::OPC_W-1:0]   req_opcode,
  input  sma_pkg::flags_t             flags,
  output sma_pkg::ctrl_t              uop
);
  import sma_pkg::*;

  typedef enum logic [1:0] {
    SEQ_IDLE = 2'b01,
    SEQ_RUN  = 2'b10
  } seq_state_t;

  seq_state_t       state;
  seq_state_t       state_next;
  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  ctrl_t            word;
  logic             taken;
  logic             stall;

  always_comb begin
    word = ucode(upc);
    case (word.cond)
      COND_NONE:     taken = 1'b0;
      COND_FULL:     taken = flags.full;
      COND_UNDER:    taken = flags.under;
      COND_DZERO:    taken = flags.depth_zero;
      COND_DMULTI:   taken = flags.depth_multi;
      COND_UNSUP:    taken = flags.unsup;
      COND_NOT_DIV:  taken = flags.not_div;
      COND_DIV_ZERO: taken = flags.div_zero;
      COND_DIV_BUSY: taken = flags.div_busy;
      default:       taken = 1'b0;
    endcase
    // A result can only be written when the output register is free.
    stall      = word.emit && flags.out_busy;
    req_ready  = (state == SEQ_IDLE);
    state_next = state;
    upc_next   = upc;
    uop        = '0;
    case (state)
      SEQ_IDLE: begin
        if (req_valid) begin
          state_next = SEQ_RUN;
          upc_next   = dispatch(req_opcode);
        end
      end
      SEQ_RUN: begin
        if (taken) begin
          upc_next = word.target;
        end else if (!stall) begin
          uop = word;
          if (word.emit) begin
            state_next = SEQ_IDLE;
          end else begin
            upc_next = upc + 1'b1;
          end
        end
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      upc   <= '0;
    end else begin
      state <= state_next;
      upc   <= upc_next;
    end
  end

  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == SEQ_RUN))
    else $error("accepted instruction did not start the program");

  a_emit_ends: assert property (@(posedge clk) disable iff (rst)
    uop.emit |=> (state == SEQ_IDLE))
    else $error("program kept running after its result");

endmodule

// ===== rtl/sma_dp.sv =====
`timescale 1ns / 1ps
// Datapath: stack memory, top and operand registers, ALU, divider and result register.
module sma_dp #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_accept,
  input  logic [sma_pkg::OPC_W-1:0]           req_opcode,
  input  logic signed [sma_pkg::DATA_W-1:0]   req_push_value,
  input  sma_pkg::ctrl_t                      uop,
  output sma_pkg::flags_t                     flags,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic [sma_pkg::STATUS_W-1:0]        rsp_status,
  output logic signed [sma_pkg::DATA_W-1:0]   rsp_top_value,
  output logic [sma_pkg::COUNT_W-1:0]         rsp_stack_count
);
  import sma_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];

  logic [DW-1:0]     depth;
  logic [DW-1:0]     depth_next;
  logic [DW-1:0]     depth_m2;
  logic [DW-1:0]     depth_m3;
  logic [DATA_W-1:0] top;
  logic [DATA_W-1:0] top_next;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] result;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] push_value;
  logic [OPC_W-1:0]  opcode;
  logic              div_busy;

  assign depth_m2 = depth - DW'(2);
  assign depth_m3 = depth - DW'(3);

  // Stack memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (uop.push_pv) begin
      stack_mem[depth[AW-1:0]] <= push_value;
    end else if (uop.push_res) begin
      stack_mem[depth_m2[AW-1:0]] <= result;
    end
    if (uop.rd_second) begin
      rdata <= stack_mem[depth_m2[AW-1:0]];
    end else if (uop.rd_below) begin
      rdata <= stack_mem[depth_m3[AW-1:0]];
    end
  end

  // The second entry is the first operand and the top of stack the other.
  always_comb begin
    case (opcode)
      ADD:     alu_res = top + opb;
      MULT:    alu_res = top * opb;
      SUB:     alu_res = opb - top;
      CMP: begin
        if ($signed(top) > $signed(opb)) begin
          alu_res = DATA_W'(1);
        end else if (top == opb) begin
          alu_res = '0;
        end else begin
          alu_res = '1;
        end
      end
      default: alu_res = '0;
    endcase
  end

  sma_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (uop.div_start),
    .num   (opb),
    .den   (top),
    .busy  (div_busy),
    .quo   (quo)
  );

  always_comb begin
    depth_next = depth;
    top_next   = top;
    if (uop.push_pv) begin
      depth_next = depth + 1'b1;
      top_next   = push_value;
    end
    if (uop.push_res) begin
      depth_next = depth - 1'b1;
      top_next   = result;
    end
    if (uop.pop_two) begin
      depth_next = depth_m2;
    end
    if (uop.clear) begin
      depth_next = '0;
    end
    if (uop.load_top) begin
      top_next = rdata;
    end
  end

  always_comb begin
    flags.full        = (depth == DW'(STACK_DEPTH));
    flags.under       = (depth < DW'(2));
    flags.depth_zero  = (depth == '0);
    flags.depth_multi = (depth > DW'(1));
    flags.unsup       = (opcode > OP_CLEAR);
    flags.not_div     = (opcode != DIV);
    flags.div_zero    = (top == '0);
    flags.div_busy    = div_busy;
    flags.out_busy    = rsp_valid && !rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      depth <= depth_next;
      if (uop.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
    if (req_accept) begin
      opcode     <= req_opcode;
      push_value <= req_push_value;
    end
    if (uop.load_b) begin
      opb <= rdata;
    end
    if (uop.load_alu) begin
      result <= alu_res;
    end else if (uop.load_quo) begin
      result <= quo;
    end
    if (uop.emit) begin
      rsp_status      <= uop.status;
      rsp_top_value   <= (depth_next == '0) ? '0 : top_next;
      rsp_stack_count <= COUNT_W'(depth_next);
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_pop_has_two: assert property (@(posedge clk) disable iff (rst)
    (uop.pop_two || uop.push_res) |-> (depth >= DW'(2)))
    else $error("operands popped from a short stack");

endmodule

// ===== rtl/stack_machine_alu.sv =====
`timescale 1ns / 1ps
// Stack calculator top level: microcode sequencer driving the stack datapath.
// One instruction in flight: the next is taken the cycle after its result is written.
// Reset (rst, synchronous) empties the stack and the result register; no clearing pass.
module stack_machine_alu #(
  parameter int STACK_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  sma_req_if.sink      req,
  sma_rsp_if.source    rsp
);
  import sma_pkg::*;

  flags_t flags;
  ctrl_t  uop;
  logic   req_ready;

  // The instruction channel is open whenever the sequencer is idle. A result still
  // waiting in the output register does not hold off the next transaction; the
  // sequencer only stalls when it is about to write a new result over it.
  assign req.ready = req_ready;

  // The sequencer fetches one control word per cycle from its store when not stalled,
  // starting at the accepted opcode's entry point, and jumps on the datapath flags.
  sma_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req.valid),
    .req_ready  (req_ready),
    .req_opcode (req.opcode),
    .flags      (flags),
    .uop        (uop)
  );

  // The datapath holds the stack in a memory with a cached top register, so a push or a
  // finish needs no read, and a successful binary operation reads only the second entry.
  sma_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .req_accept      (req.valid && req_ready),
    .req_opcode      (req.opcode),
    .req_push_value  (req.push_value),
    .uop             (uop),
    .flags           (flags),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_top_value   (rsp.top_value),
    .rsp_stack_count (rsp.stack_count)
  );

endmodule
